// File: rtl/wavhv_pkg.sv
// ============================================================================
// WAV header validator package
// Shared widths, tag constants, register indexes and verdict codes.
// ============================================================================
package wavhv_pkg;

    // Byte position and chunk start are kept one bit wider than the file
    // size plus the small header offsets, so chunk arithmetic never wraps.
    localparam int unsigned POS_W    = 34;
    localparam int unsigned FMT_OFF_W = 5;
    localparam int unsigned PROD_W   = 48;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 72;

    // Four-character tags, first character in the top byte.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SECONDS  = 2'd3;

    // Configuration reset values.
    localparam logic [31:0] FILE_SIZE_RST    = 32'd0;
    localparam logic [15:0] MAX_CHANNELS_RST = 16'd2;
    localparam logic [31:0] SAMPLE_RATE_RST  = 32'd44100;
    localparam logic [15:0] MAX_SECONDS_RST  = 16'd10;

    // Fixed header values.
    localparam logic [POS_W-1:0]     FIRST_CHUNK  = 34'd12;
    localparam logic [7:0]           PCM_TAG_LOW  = 8'h01;
    localparam logic [15:0]          WIDTH_8      = 16'd8;
    localparam logic [15:0]          WIDTH_16     = 16'd16;
    localparam logic [FMT_OFF_W-1:0] FMT_FIRST    = 5'd8;

    // Capture offsets inside a fmt chunk.
    localparam logic [FMT_OFF_W-1:0] FOFF_PCM_LO  = 5'd8;
    localparam logic [FMT_OFF_W-1:0] FOFF_PCM_HI  = 5'd9;
    localparam logic [FMT_OFF_W-1:0] FOFF_CH_LO   = 5'd10;
    localparam logic [FMT_OFF_W-1:0] FOFF_CH_HI   = 5'd11;
    localparam logic [FMT_OFF_W-1:0] FOFF_RATE0   = 5'd12;
    localparam logic [FMT_OFF_W-1:0] FOFF_RATE3   = 5'd15;
    localparam logic [FMT_OFF_W-1:0] FOFF_BRATE0  = 5'd16;
    localparam logic [FMT_OFF_W-1:0] FOFF_BRATE3  = 5'd19;
    localparam logic [FMT_OFF_W-1:0] FOFF_BITS_LO = 5'd22;
    localparam logic [FMT_OFF_W-1:0] FOFF_BITS_HI = 5'd23;

    // Verdict codes.
    typedef logic [2:0] status_t;
    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_NOT_WAVE   = 3'd1;
    localparam status_t ST_CHUNK_SIZE = 3'd2;
    localparam status_t ST_NOT_PCM    = 3'd3;
    localparam status_t ST_CHANNELS   = 3'd4;
    localparam status_t ST_RATE       = 3'd5;
    localparam status_t ST_WORD_SIZE  = 3'd6;
    localparam status_t ST_TOO_LONG   = 3'd7;

endpackage

// File: rtl/wav_header_validator_top.sv
// ============================================================================
// WAV header validator
// Streams a RIFF/WAVE file one byte per transfer and reports one verdict with
// the format fields at the byte marked as the last one of the file.
// ============================================================================
//
// The block takes one file byte per clock on the s_ channel while s_tready is
// high, with s_tlast on the final byte of the file, and returns exactly one
// result transfer per file on the m_ channel. Each byte is absorbed in the
// cycle it is accepted: tag checks, the chunk walk (one subtract and compare
// against the current chunk start, one add for the next chunk start) and fmt
// field capture all update the parser registers directly, so a byte can be
// taken in every cycle and the next file may start right after the last byte
// of the previous one. The verdict goes through a three-register pipeline: a
// snapshot of the final fields, then the clip-length product
// max_clip_seconds * bytes_per_second (a 16 x 32 multiply) with the other
// checks, then the length compare into the output register. s_tready drops
// only when that pipeline is full and the result is not taken. Status codes:
// 0 ok, 1 not RIFF/WAVE or short file, 2 chunk length too large, 3 not PCM,
// 4 channel count, 5 sample rate, 6 word size, 7 no data or clip too long.
// The lowest status code that applies wins. Configuration is written through
// cfg_* (index 0 file size, 1 max channels, 2 required sample rate, 3 max clip
// seconds); the user must write it only while no file is in progress, as the
// block itself does not enforce this.
module wav_header_validator_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream: tdata = file_byte[7:0]; tlast = last_byte.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wavhv_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    // Result stream: tdata = status[2:0], channel_count[18:3],
    // sample_width[34:19], data_length[66:35], zeros[71:67].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wavhv_pkg::M_DATA_W-1:0]      m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wavhv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wavhv_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wavhv_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [31:0] file_size_reg;
    logic [15:0] max_channels_reg;
    logic [31:0] sample_rate_reg;
    logic [15:0] max_seconds_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg    <= FILE_SIZE_RST;
            max_channels_reg <= MAX_CHANNELS_RST;
            sample_rate_reg  <= SAMPLE_RATE_RST;
            max_seconds_reg  <= MAX_SECONDS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FILE_SIZE:    file_size_reg    <= cfg_data;
                REG_MAX_CHANNELS: max_channels_reg <= cfg_data[15:0];
                REG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data;
                REG_MAX_SECONDS:  max_seconds_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     chunk_start_reg, chunk_start_next;
    logic [31:0]          chunk_size_reg, chunk_size_next;
    logic [31:0]          chunk_tag_reg, chunk_tag_next;
    logic                 pcm_seen_reg, pcm_seen_next;
    logic [15:0]          channels_reg, channels_next;
    logic [31:0]          rate_reg, rate_next;
    logic [15:0]          width_reg, width_next;
    logic [31:0]          byte_rate_reg, byte_rate_next;
    logic [31:0]          data_size_reg, data_size_next;
    status_t              first_error_reg, first_error_next;
    logic                 walk_done_reg, walk_done_next;
    logic                 fmt_active_reg, fmt_active_next;
    logic [FMT_OFF_W-1:0] fmt_off_reg, fmt_off_next;
    logic                 pcm_low_ok_reg, pcm_low_ok_next;

    logic       s_accept;
    logic [7:0] in_byte;
    logic       file_end;

    assign s_accept = s_tvalid && s_tready;
    assign in_byte  = s_tdata[7:0];
    assign file_end = s_accept && s_tlast;

    // Distance from the current chunk start, used to spot header bytes.
    logic [POS_W:0]   hdr_diff;
    logic             in_header;
    logic [2:0]       hdr_off;
    logic [POS_W+1:0] chunk_end_ext;
    logic [POS_W+1:0] size_limit_ext;
    logic [POS_W:0]   hdr_end_ext;

    assign hdr_diff  = {1'b0, pos_reg} - {1'b0, chunk_start_reg};
    assign in_header = !walk_done_reg && !hdr_diff[POS_W] && (hdr_diff[POS_W-1:3] == '0);
    assign hdr_off   = hdr_diff[2:0];

    always_comb begin
        pos_next         = pos_reg + 1'b1;
        chunk_start_next = chunk_start_reg;
        chunk_size_next  = chunk_size_reg;
        chunk_tag_next   = chunk_tag_reg;
        pcm_seen_next    = pcm_seen_reg;
        channels_next    = channels_reg;
        rate_next        = rate_reg;
        width_next       = width_reg;
        byte_rate_next   = byte_rate_reg;
        data_size_next   = data_size_reg;
        first_error_next = first_error_reg;
        walk_done_next   = walk_done_reg;
        fmt_active_next  = fmt_active_reg;
        fmt_off_next     = fmt_off_reg;
        pcm_low_ok_next  = pcm_low_ok_reg;
        chunk_end_ext    = '0;
        size_limit_ext   = '0;
        hdr_end_ext      = '0;

        // RIFF tag at bytes 0..3 and WAVE tag at bytes 8..11.
        if (pos_reg < FIRST_CHUNK) begin
            if (pos_reg <= 34'd3 || pos_reg >= 34'd8) begin
                chunk_tag_next = {chunk_tag_reg[23:0], in_byte};
            end
            if (pos_reg == 34'd3 && chunk_tag_next != TAG_RIFF && first_error_reg == ST_OK) begin
                first_error_next = ST_NOT_WAVE;
                walk_done_next   = 1'b1;
            end
            if (pos_reg == 34'd11 && chunk_tag_next != TAG_WAVE && first_error_reg == ST_OK) begin
                first_error_next = ST_NOT_WAVE;
                walk_done_next   = 1'b1;
            end
        end

        // Fmt field capture, little-endian fields at fixed offsets.
        if (fmt_active_reg) begin
            fmt_off_next = fmt_off_reg + 1'b1;
            case (fmt_off_reg) inside
                FOFF_PCM_LO: pcm_low_ok_next = (in_byte == PCM_TAG_LOW);
                FOFF_PCM_HI: begin
                    if (pcm_low_ok_reg && in_byte == 8'h00) begin
                        pcm_seen_next = 1'b1;
                    end
                end
                FOFF_CH_LO: channels_next[7:0]  = in_byte;
                FOFF_CH_HI: channels_next[15:8] = in_byte;
                [FOFF_RATE0:FOFF_RATE3]: rate_next[8*fmt_off_reg[1:0] +: 8] = in_byte;
                [FOFF_BRATE0:FOFF_BRATE3]: byte_rate_next[8*fmt_off_reg[1:0] +: 8] = in_byte;
                FOFF_BITS_LO: width_next[7:0] = in_byte;
                FOFF_BITS_HI: begin
                    width_next[15:8] = in_byte;
                    fmt_active_next  = 1'b0;
                end
                default: ;
            endcase
        end

        // Chunk header: four tag bytes, then a little-endian length.
        if (in_header) begin
            if (!hdr_off[2]) begin
                chunk_tag_next = {chunk_tag_reg[23:0], in_byte};
            end else begin
                chunk_size_next[8*hdr_off[1:0] +: 8] = in_byte;
            end
            if (hdr_off == 3'd7) begin
                hdr_end_ext    = {1'b0, chunk_start_reg} + (POS_W+1)'(8);
                size_limit_ext = {2'b00, chunk_start_reg} + {{(POS_W-30){1'b0}}, chunk_size_next}
                                 + (POS_W+2)'(4);
                chunk_end_ext  = {2'b00, chunk_start_reg} + {{(POS_W-30){1'b0}}, chunk_size_next}
                                 + (POS_W+2)'(8);
                if (hdr_end_ext >= {{(POS_W-31){1'b0}}, file_size_reg}) begin
                    walk_done_next = 1'b1;
                end else if (size_limit_ext > {{(POS_W-30){1'b0}}, file_size_reg}) begin
                    if (first_error_next == ST_OK) begin
                        first_error_next = ST_CHUNK_SIZE;
                    end
                    walk_done_next = 1'b1;
                end else begin
                    if (chunk_tag_reg == TAG_FMT) begin
                        fmt_active_next = 1'b1;
                        fmt_off_next    = FMT_FIRST;
                        pcm_low_ok_next = 1'b0;
                    end else if (chunk_tag_reg == TAG_DATA) begin
                        data_size_next = chunk_size_next;
                    end
                    chunk_start_next = chunk_end_ext[POS_W-1:0];
                    chunk_size_next  = '0;
                end
            end
        end
    end

    // The final byte of a file returns the parser to its reset state.
    always_ff @(posedge aclk) begin
        if (!aresetn || file_end) begin
            pos_reg         <= '0;
            chunk_start_reg <= FIRST_CHUNK;
            chunk_size_reg  <= '0;
            chunk_tag_reg   <= '0;
            pcm_seen_reg    <= 1'b0;
            channels_reg    <= '0;
            rate_reg        <= '0;
            width_reg       <= '0;
            byte_rate_reg   <= '0;
            data_size_reg   <= '0;
            first_error_reg <= ST_OK;
            walk_done_reg   <= 1'b0;
            fmt_active_reg  <= 1'b0;
            fmt_off_reg     <= '0;
            pcm_low_ok_reg  <= 1'b0;
        end else if (s_accept) begin
            pos_reg         <= pos_next;
            chunk_start_reg <= chunk_start_next;
            chunk_size_reg  <= chunk_size_next;
            chunk_tag_reg   <= chunk_tag_next;
            pcm_seen_reg    <= pcm_seen_next;
            channels_reg    <= channels_next;
            rate_reg        <= rate_next;
            width_reg       <= width_next;
            byte_rate_reg   <= byte_rate_next;
            data_size_reg   <= data_size_next;
            first_error_reg <= first_error_next;
            walk_done_reg   <= walk_done_next;
            fmt_active_reg  <= fmt_active_next;
            fmt_off_reg     <= fmt_off_next;
            pcm_low_ok_reg  <= pcm_low_ok_next;
        end
    end

    // ------------------------------------------------------------------
    // Verdict pipeline: snapshot -> checks and product -> output.
    // ------------------------------------------------------------------
    logic snap_valid_reg, chk_valid_reg, out_valid_reg;
    logic out_free, chk_free, snap_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign chk_free  = !chk_valid_reg || out_free;
    assign snap_free = !snap_valid_reg || chk_free;
    assign s_tready  = snap_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (snap_free) begin
                snap_valid_reg <= file_end;
            end
            if (chk_free) begin
                chk_valid_reg <= snap_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= chk_valid_reg;
            end
        end
    end

    // Snapshot of the fields as they stand after the last byte.
    logic        snap_short_reg;
    status_t     snap_error_reg;
    logic        snap_pcm_reg;
    logic [15:0] snap_channels_reg;
    logic [31:0] snap_rate_reg;
    logic [15:0] snap_width_reg;
    logic [31:0] snap_byte_rate_reg;
    logic [31:0] snap_data_reg;

    always_ff @(posedge aclk) begin
        if (snap_free && file_end) begin
            snap_short_reg     <= (pos_reg < 34'd11);
            snap_error_reg     <= first_error_next;
            snap_pcm_reg       <= pcm_seen_next;
            snap_channels_reg  <= channels_next;
            snap_rate_reg      <= rate_next;
            snap_width_reg     <= width_next;
            snap_byte_rate_reg <= byte_rate_next;
            snap_data_reg      <= data_size_next;
        end
    end

    // Every check but the clip length, in order of status code.
    status_t pre_status;

    always_comb begin
        if (snap_short_reg) begin
            pre_status = ST_NOT_WAVE;
        end else if (snap_error_reg != ST_OK) begin
            pre_status = snap_error_reg;
        end else if (!snap_pcm_reg) begin
            pre_status = ST_NOT_PCM;
        end else if (snap_channels_reg == 16'd0 || snap_channels_reg > max_channels_reg) begin
            pre_status = ST_CHANNELS;
        end else if (snap_rate_reg != sample_rate_reg) begin
            pre_status = ST_RATE;
        end else if (snap_width_reg != WIDTH_16 && snap_width_reg != WIDTH_8) begin
            pre_status = ST_WORD_SIZE;
        end else if (snap_data_reg == 32'd0) begin
            pre_status = ST_TOO_LONG;
        end else begin
            pre_status = ST_OK;
        end
    end

    status_t           chk_status_reg;
    logic [PROD_W-1:0] chk_limit_reg;
    logic [15:0]       chk_channels_reg;
    logic [15:0]       chk_width_reg;
    logic [31:0]       chk_data_reg;

    always_ff @(posedge aclk) begin
        if (chk_free && snap_valid_reg) begin
            chk_status_reg   <= pre_status;
            chk_limit_reg    <= max_seconds_reg * snap_byte_rate_reg;
            chk_channels_reg <= snap_channels_reg;
            chk_width_reg    <= snap_width_reg;
            chk_data_reg     <= snap_data_reg;
        end
    end

    // Clip length test: data length above seconds times bytes per second.
    status_t out_status_reg;
    logic [15:0] out_channels_reg;
    logic [15:0] out_width_reg;
    logic [31:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (out_free && chk_valid_reg) begin
            if (chk_status_reg != ST_OK) begin
                out_status_reg <= chk_status_reg;
            end else if ({{(PROD_W-32){1'b0}}, chk_data_reg} > chk_limit_reg) begin
                out_status_reg <= ST_TOO_LONG;
            end else begin
                out_status_reg <= ST_OK;
            end
            out_channels_reg <= chk_channels_reg;
            out_width_reg    <= chk_width_reg;
            out_data_reg     <= chk_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_data_reg, out_width_reg, out_channels_reg, out_status_reg};

endmodule
